FILE: design/macs_pkg.sv
// Shared types and constants for the moving-average crossover signal block.
`timescale 1ns / 1ps
`default_nettype none

package macs_pkg;

  // Field and register widths fixed by the interface
  localparam int PRICE_FIELD_BITS = 32;
  localparam int WIN_BITS         = 9;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int CFG_DATA_BITS    = 32;
  localparam int CFG_ADDR_LSB     = 2;

  // Register map
  typedef enum logic [0:0] {
    REG_SHORT_WINDOW = 1'b0,
    REG_LONG_WINDOW  = 1'b1
  } reg_idx_e;

  localparam logic [WIN_BITS-1:0] SHORT_WINDOW_RESET = 9'd5;
  localparam logic [WIN_BITS-1:0] LONG_WINDOW_RESET  = 9'd20;

  // Relation of the short average to the long average
  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_ABOVE = 2'd1,
    REL_BELOW = 2'd2
  } rel_e;

  // Trade signal codes
  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_e;

  // Input item
  typedef struct packed {
    logic [PRICE_FIELD_BITS-1:0] close_price;
    logic                        series_start;
  } macs_in_t;

  // Result item
  typedef struct packed {
    logic [1:0] trade_signal;
    logic       holding_position;
  } macs_out_t;

  // Sideband that travels with an item along the multiplier chain
  typedef struct packed {
    logic valid;
    logic start;
    logic first;
  } macs_ctrl_t;

endpackage

`default_nettype wire

FILE: design/macs_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module macs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and read both ports (old data on a collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: design/macs_cell.sv
// One shift-add cell of the cross-multiply chain: handles one multiplier bit per product.
`timescale 1ns / 1ps
`default_nettype none

module macs_cell #(
  parameter int PRW = 49,
  parameter int CW  = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  macs_pkg::macs_ctrl_t ctrl_i,
  input  logic [PRW-1:0]       mcand_a_i,
  input  logic [CW-1:0]        mplier_a_i,
  input  logic [PRW-1:0]       acc_a_i,
  input  logic [PRW-1:0]       mcand_b_i,
  input  logic [CW-1:0]        mplier_b_i,
  input  logic [PRW-1:0]       acc_b_i,
  output macs_pkg::macs_ctrl_t ctrl_o,
  output logic [PRW-1:0]       mcand_a_o,
  output logic [CW-1:0]        mplier_a_o,
  output logic [PRW-1:0]       acc_a_o,
  output logic [PRW-1:0]       mcand_b_o,
  output logic [CW-1:0]        mplier_b_o,
  output logic [PRW-1:0]       acc_b_o
);

  macs_pkg::macs_ctrl_t ctrl_q;
  logic [PRW-1:0] mcand_a_q, acc_a_q, mcand_b_q, acc_b_q;
  logic [CW-1:0]  mplier_a_q, mplier_b_q;
  logic [PRW-1:0] acc_a_d, acc_b_d;

  // Add the partial product selected by the low multiplier bit
  assign acc_a_d = acc_a_i + (mplier_a_i[0] ? mcand_a_i : '0);
  assign acc_b_d = acc_b_i + (mplier_b_i[0] ? mcand_b_i : '0);

  // Advance the item tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the partial products; shift the multiplicand up and the multiplier down
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_a_q    <= acc_a_d;
      acc_b_q    <= acc_b_d;
      mcand_a_q  <= {mcand_a_i[PRW-2:0], 1'b0};
      mcand_b_q  <= {mcand_b_i[PRW-2:0], 1'b0};
      mplier_a_q <= mplier_a_i >> 1;
      mplier_b_q <= mplier_b_i >> 1;
    end
  end

  assign ctrl_o     = ctrl_q;
  assign mcand_a_o  = mcand_a_q;
  assign mplier_a_o = mplier_a_q;
  assign acc_a_o    = acc_a_q;
  assign mcand_b_o  = mcand_b_q;
  assign mplier_b_o = mplier_b_q;
  assign acc_b_o    = acc_b_q;

endmodule

`default_nettype wire

FILE: design/moving_average_crossover_signal_top.sv
// Top level of the moving-average crossover signal generator.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one closing price
// and a series-start flag per transfer; the output channel (out_valid_o /
// out_ready_i / out_data_o) carries one trade signal and the position flag per
// input transfer, in order. The APB port holds the short and long window
// lengths at byte addresses 0 and 4; write them only while the block is idle.
//
// Throughput: one item per clock cycle while the receiver keeps up. The front
// stage updates both running sums in the transfer cycle from a ring RAM whose
// two registered read ports are addressed ahead for the next item. The
// cross-multiply runs from a launch register through a chain of
// $clog2(MAX_WINDOW+1) shift-add cells into the output register.
//
// Reset: windows return to 5 and 20, sums, sample count, pointer, relation and
// position clear. The ring contents stay undefined; no clearing pass is run.
// When the receiver stalls with a result waiting, the whole chain freezes and
// in_ready_o drops until that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_crossover_signal_top #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [macs_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [macs_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [macs_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  macs_pkg::macs_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output macs_pkg::macs_out_t                   out_data_o
);

  import macs_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int PW   = PRICE_BITS;
  localparam int SUMW = PW + AW;
  localparam int PRW  = SUMW + CW;
  localparam int NC   = CW;

  // Clamp a window register to 1..MAX_WINDOW
  function automatic logic [CW-1:0] eff_win(input logic [WIN_BITS-1:0] w);
    logic [CW-1:0] r;
    if (w == '0) begin
      r = CW'(1);
    end else if (32'(w) > 32'(MAX_WINDOW)) begin
      r = CW'(MAX_WINDOW);
    end else begin
      r = CW'(w);
    end
    return r;
  endfunction

  // Ring slot written w items before slot p
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
                                              input logic [CW-1:0] w);
    logic [CW:0] t;
    t = (CW+1)'(p) + (CW+1)'(MAX_WINDOW) - (CW+1)'(w);
    if (t >= (CW+1)'(MAX_WINDOW)) begin
      t = t - (CW+1)'(MAX_WINDOW);
    end
    return t[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                cfg_we;
  reg_idx_e            cfg_idx;
  logic [WIN_BITS-1:0] short_q, short_d, long_q, long_d;
  logic [WIN_BITS-1:0] rd_reg;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[CFG_ADDR_LSB]);
  assign pready  = 1'b1;

  // Take a register write
  always_comb begin
    short_d = short_q;
    long_d  = long_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_SHORT_WINDOW: short_d = pwdata[WIN_BITS-1:0];
        REG_LONG_WINDOW:  long_d  = pwdata[WIN_BITS-1:0];
        default:          short_d = short_q;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_SHORT_WINDOW: rd_reg = short_q;
      REG_LONG_WINDOW:  rd_reg = long_q;
      default:          rd_reg = short_q;
    endcase
  end
  assign prdata = CFG_DATA_BITS'(rd_reg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_WINDOW_RESET;
      long_q  <= LONG_WINDOW_RESET;
    end else begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline enable
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic en, accept;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // ---------------------------------------------------------------------------
  // Front stage: ring and running sums
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   ws, wl, ws_nx, wl_nx;
  logic [63:0]     price_ext;
  logic [PW-1:0]   price;
  logic            start, first;
  logic [SUMW-1:0] ss_q, ss_d, sl_q, sl_d, ss_cur, sl_cur, ss_new, sl_new;
  logic [CW-1:0]   seen_q, seen_d, seen_cur, seen_nx;
  logic [AW-1:0]   wp_q, wp_d, wp_nx;
  logic            full_s, full_l;
  logic [CW-1:0]   ns, nl;
  logic [AW-1:0]   ra_s, ra_l;
  logic [PW-1:0]   rdata_s, rdata_l, drop_s, drop_l;
  logic            byp_s_q, byp_l_q;
  logic [PW-1:0]   byp_price_q;

  assign ws    = eff_win(short_q);
  assign wl    = eff_win(long_q);
  assign ws_nx = eff_win(short_d);
  assign wl_nx = eff_win(long_d);

  assign price_ext = 64'(in_data_i.close_price);
  assign price     = price_ext[PW-1:0];
  assign start     = in_data_i.series_start;

  // Clear the series state on a start flag
  assign ss_cur   = start ? '0 : ss_q;
  assign sl_cur   = start ? '0 : sl_q;
  assign seen_cur = start ? '0 : seen_q;
  assign first    = (seen_cur == '0);

  // Drop the oldest price once a window is full
  assign drop_s = byp_s_q ? byp_price_q : rdata_s;
  assign drop_l = byp_l_q ? byp_price_q : rdata_l;
  assign full_s = (seen_cur >= ws);
  assign full_l = (seen_cur >= wl);
  assign ss_new = ss_cur + SUMW'(price) - (full_s ? SUMW'(drop_s) : '0);
  assign sl_new = sl_cur + SUMW'(price) - (full_l ? SUMW'(drop_l) : '0);
  assign ns     = full_s ? ws : seen_cur + CW'(1);
  assign nl     = full_l ? wl : seen_cur + CW'(1);

  assign seen_nx = (seen_cur < CW'(MAX_WINDOW)) ? seen_cur + CW'(1) : seen_cur;
  assign wp_nx   = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);

  assign ss_d   = accept ? ss_new  : ss_q;
  assign sl_d   = accept ? sl_new  : sl_q;
  assign seen_d = accept ? seen_nx : seen_q;
  assign wp_d   = accept ? wp_nx   : wp_q;

  // Fetch the slots that the next item drops
  assign ra_s = ring_back(wp_d, ws_nx);
  assign ra_l = ring_back(wp_d, wl_nx);

  macs_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (wp_q),
    .wdata_i   (price),
    .raddr_a_i (ra_s),
    .rdata_a_o (rdata_s),
    .raddr_b_i (ra_l),
    .rdata_b_o (rdata_l)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q    <= '0;
      sl_q    <= '0;
      seen_q  <= '0;
      wp_q    <= '0;
      byp_s_q <= 1'b0;
      byp_l_q <= 1'b0;
    end else begin
      ss_q    <= ss_d;
      sl_q    <= sl_d;
      seen_q  <= seen_d;
      wp_q    <= wp_d;
      // Forward the price being written when it is the slot being read
      byp_s_q <= accept && (ra_s == wp_q);
      byp_l_q <= accept && (ra_l == wp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_price_q <= price;
  end

  // ---------------------------------------------------------------------------
  // Launch register and shift-add chain
  // ---------------------------------------------------------------------------
  macs_ctrl_t     s0_ctrl_q;
  logic [PRW-1:0] s0_mca_q, s0_mcb_q;
  logic [CW-1:0]  s0_mpa_q, s0_mpb_q;

  macs_ctrl_t     ctl   [NC+1];
  logic [PRW-1:0] mca   [NC+1];
  logic [PRW-1:0] mcb   [NC+1];
  logic [CW-1:0]  mpa   [NC+1];
  logic [CW-1:0]  mpb   [NC+1];
  logic [PRW-1:0] acc_a [NC+1];
  logic [PRW-1:0] acc_b [NC+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctrl_q <= '0;
    end else if (en) begin
      s0_ctrl_q.valid <= accept;
      s0_ctrl_q.start <= start;
      s0_ctrl_q.first <= first;
    end
  end

  // Launch Ss * nl and Sl * ns
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mca_q <= PRW'(ss_new);
      s0_mpa_q <= nl;
      s0_mcb_q <= PRW'(sl_new);
      s0_mpb_q <= ns;
    end
  end

  assign ctl[0]   = s0_ctrl_q;
  assign mca[0]   = s0_mca_q;
  assign mpa[0]   = s0_mpa_q;
  assign mcb[0]   = s0_mcb_q;
  assign mpb[0]   = s0_mpb_q;
  assign acc_a[0] = '0;
  assign acc_b[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    macs_cell #(
      .PRW (PRW),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .ctrl_i     (ctl[i]),
      .mcand_a_i  (mca[i]),
      .mplier_a_i (mpa[i]),
      .acc_a_i    (acc_a[i]),
      .mcand_b_i  (mcb[i]),
      .mplier_b_i (mpb[i]),
      .acc_b_i    (acc_b[i]),
      .ctrl_o     (ctl[i+1]),
      .mcand_a_o  (mca[i+1]),
      .mplier_a_o (mpa[i+1]),
      .acc_a_o    (acc_a[i+1]),
      .mcand_b_o  (mcb[i+1]),
      .mplier_b_o (mpb[i+1]),
      .acc_b_o    (acc_b[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Crossing decision and output register
  // ---------------------------------------------------------------------------
  macs_ctrl_t ctl_end;
  rel_e       rel, prev_q, prev_eff;
  logic       pos_q, pos_eff, pos_new;
  sig_e       sig;
  macs_out_t  out_data_q;

  assign ctl_end = ctl[NC];

  // Compare the cross products
  always_comb begin
    if (acc_a[NC] > acc_b[NC]) begin
      rel = REL_ABOVE;
    end else if (acc_a[NC] < acc_b[NC]) begin
      rel = REL_BELOW;
    end else begin
      rel = REL_EQUAL;
    end
  end

  assign prev_eff = ctl_end.start ? REL_EQUAL : prev_q;
  assign pos_eff  = ctl_end.start ? 1'b0 : pos_q;

  // Open on an upward cross, close on a downward cross
  always_comb begin
    sig     = SIG_HOLD;
    pos_new = pos_eff;
    if (!ctl_end.first) begin
      if (rel == REL_ABOVE && prev_eff != REL_ABOVE) begin
        if (!pos_eff) begin
          sig     = SIG_BUY;
          pos_new = 1'b1;
        end
      end else if (rel == REL_BELOW && prev_eff != REL_BELOW) begin
        if (pos_eff) begin
          sig     = SIG_SELL;
          pos_new = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q      <= REL_EQUAL;
      pos_q       <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_end.valid;
      if (ctl_end.valid) begin
        prev_q <= rel;
        pos_q  <= pos_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && ctl_end.valid) begin
      out_data_q.trade_signal     <= sig;
      out_data_q.holding_position <= pos_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: design/macs_checker.sv
// Port-level checker for the crossover signal top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module macs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input macs_pkg::macs_out_t out_data_o
);

  import macs_pkg::*;

  logic       in_xfer, out_xfer;
  logic [7:0] inflight_q, inflight_d;
  logic       prev_hold_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Count items accepted but not yet delivered
  assign inflight_d = inflight_q + 8'(in_xfer) - 8'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= '0;
      prev_hold_q <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      if (out_xfer) begin
        prev_hold_q <= out_data_o.holding_position;
      end
    end
  end

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // No result without an accepted item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 8'd0)
    else $error("result with no item in flight");

  // A buy opens a position that was not held
  a_buy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trade_signal == SIG_BUY
      |-> out_data_o.holding_position && !prev_hold_q)
    else $error("buy without opening a position");

  // A sell closes a held position; a hold never opens one
  a_sell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trade_signal != SIG_BUY
      |-> !(out_data_o.holding_position && !prev_hold_q)
          && (out_data_o.trade_signal != SIG_SELL
              || (!out_data_o.holding_position && prev_hold_q)))
    else $error("position changed without a matching signal");

endmodule

bind moving_average_crossover_signal_top macs_checker u_macs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the moving-average crossover signal block.
`timescale 1ns / 1ps

module tb;
  import macs_pkg::*;

  localparam int     HALF_PERIOD    = 10;
  localparam int     RESET_CYCLES   = 5;
  localparam int     HIST_DEPTH     = 256;
  localparam int     SUM_BITS       = 40;
  localparam int     PIPE_LATENCY   = 11;
  localparam int     HOLDOFF_CYCLES = 60;
  localparam int     MAX_REPORTS    = 10;
  localparam int     DIR_ROWS       = 25;
  localparam longint TIMEOUT_NS     = 4_000_000;

  localparam macs_out_t START_RESULT = '{trade_signal: SIG_HOLD, holding_position: 1'b0};

  // One row of the directed table; golden is used only where typed is set
  typedef struct packed {
    logic [PRICE_FIELD_BITS-1:0] price;
    logic                        start;
    logic                        typed;
    macs_out_t                   golden;
  } dir_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr       = '0;
  logic [CFG_DATA_BITS-1:0] pwdata      = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  macs_in_t                 in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  macs_out_t                out_data_o;

  // Typed expectation traveling with the offered price
  logic      row_typed  = 1'b0;
  macs_out_t row_golden = '0;

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic holdoff_req   = 1'b0;
  int   err_count     = 0;

  macs_out_t pending_signals[$];

  // Predictor state
  logic [WIN_BITS-1:0]         short_len   = SHORT_WINDOW_RESET;
  logic [WIN_BITS-1:0]         long_len    = LONG_WINDOW_RESET;
  logic [PRICE_FIELD_BITS-1:0] price_hist [HIST_DEPTH];
  logic [7:0]                  hist_ptr    = '0;
  logic [SUM_BITS-1:0]         short_sum   = '0;
  logic [SUM_BITS-1:0]         long_sum    = '0;
  logic [8:0]                  seen_cnt    = '0;
  rel_e                        last_rel    = REL_EQUAL;
  logic                        in_position = 1'b0;

  // Random walk that drives the price series
  logic [31:0] walk_level = 32'd50000;
  logic        walk_up    = 1'b1;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{32'hFFFF_FFFF, 1'b1, 1'b1, START_RESULT},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'd1000,      1'b1, 1'b1, START_RESULT},
    '{32'd1100,      1'b0, 1'b0, '0},
    '{32'd1200,      1'b0, 1'b0, '0},
    '{32'd1300,      1'b0, 1'b0, '0},
    '{32'd1400,      1'b0, 1'b0, '0},
    '{32'd1500,      1'b0, 1'b0, '0},
    '{32'd1600,      1'b0, 1'b0, '0},
    '{32'd0,         1'b0, 1'b0, '0},
    '{32'd0,         1'b0, 1'b0, '0},
    '{32'd0,         1'b0, 1'b0, '0},
    '{32'd5000,      1'b0, 1'b0, '0},
    '{32'd6000,      1'b0, 1'b0, '0},
    '{32'd7000,      1'b0, 1'b0, '0},
    '{32'd8000,      1'b0, 1'b0, '0},
    '{32'd9000,      1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b1, 1'b1, START_RESULT},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'd0,         1'b0, 1'b0, '0},
    '{32'd1,         1'b1, 1'b1, START_RESULT},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0}
  };

  moving_average_crossover_signal_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Map a window register to the length in use
  function automatic logic [8:0] span_of(input logic [WIN_BITS-1:0] w);
    if (w == '0) return 9'd1;
    if (w > 9'd256) return 9'd256;
    return w;
  endfunction

  // Add the new price; once the window is full, drop the one leaving it
  function automatic logic [SUM_BITS-1:0] slide_sum(input logic [SUM_BITS-1:0] sum,
                                                    input logic [31:0] price,
                                                    input logic [8:0] span,
                                                    output logic [8:0] cnt);
    logic [SUM_BITS-1:0] acc;
    logic [7:0]          old_idx;
    acc = sum + SUM_BITS'(price);
    if (seen_cnt >= span) begin
      old_idx = hist_ptr - span[7:0];
      acc     = acc - SUM_BITS'(price_hist[old_idx]);
      cnt     = span;
    end else begin
      cnt = seen_cnt + 9'd1;
    end
    return acc;
  endfunction

  // Take one price and return the trade signal it produces
  function automatic macs_out_t advance_crossover(input macs_in_t item);
    logic [8:0]  n_short;
    logic [8:0]  n_long;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        opening;
    rel_e        now_rel;
    macs_out_t   res;
    if (item.series_start) begin
      short_sum   = '0;
      long_sum    = '0;
      seen_cnt    = '0;
      last_rel    = REL_EQUAL;
      in_position = 1'b0;
    end
    opening   = (seen_cnt == '0);
    short_sum = slide_sum(short_sum, item.close_price, span_of(short_len), n_short);
    long_sum  = slide_sum(long_sum, item.close_price, span_of(long_len), n_long);
    price_hist[hist_ptr] = item.close_price;
    hist_ptr = hist_ptr + 8'd1;
    if (seen_cnt < 9'd256) seen_cnt = seen_cnt + 9'd1;

    // Compare the averages by cross-multiplying sum and count
    lhs = 64'(short_sum) * 64'(n_long);
    rhs = 64'(long_sum) * 64'(n_short);
    if (lhs > rhs) now_rel = REL_ABOVE;
    else if (lhs < rhs) now_rel = REL_BELOW;
    else now_rel = REL_EQUAL;

    res.trade_signal = SIG_HOLD;
    if (!opening) begin
      if (now_rel == REL_ABOVE && last_rel != REL_ABOVE) begin
        if (!in_position) begin
          res.trade_signal = SIG_BUY;
          in_position      = 1'b1;
        end
      end else if (now_rel == REL_BELOW && last_rel != REL_BELOW) begin
        if (in_position) begin
          res.trade_signal = SIG_SELL;
          in_position      = 1'b0;
        end
      end
    end
    last_rel = now_rel;
    res.holding_position = in_position;
    return res;
  endfunction

  // Draw the next price: mostly a trending walk, some extremes and noise
  function automatic macs_in_t draw_price(input int start_odds);
    macs_in_t item;
    int       pick;
    longint   nxt;
    pick = $urandom_range(0, 99);
    item.series_start = (start_odds != 0) && ($urandom_range(1, start_odds) == 1);
    if (item.series_start) walk_level = $urandom;
    if ($urandom_range(0, 14) == 0) walk_up = !walk_up;
    if (pick < 6) begin
      item.close_price = pick[0] ? '1 : '0;
    end else if (pick < 18) begin
      item.close_price = $urandom;
    end else begin
      if (walk_up) nxt = longint'(walk_level) + longint'($urandom_range(0, 3000)) - 1000;
      else nxt = longint'(walk_level) + 1000 - longint'($urandom_range(0, 3000));
      if (nxt < 0) nxt = 0;
      else if (nxt > 64'sd4294967295) nxt = 64'sd4294967295;
      walk_level       = nxt[31:0];
      item.close_price = walk_level;
    end
    return item;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] golden,
                            input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $time, golden, got);
  endtask

  // Predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin : scoreboard
    macs_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = advance_crossover(in_data_i);
        if (row_typed) want = row_golden;
        pending_signals.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_signals.size() == 0) begin
          flag_error("unexpected result", 32'd0, 32'(out_data_o));
        end else begin
          want = pending_signals.pop_front();
          if (out_data_o.trade_signal !== want.trade_signal)
            flag_error("trade_signal", 32'(want.trade_signal), 32'(out_data_o.trade_signal));
          if (out_data_o.holding_position !== want.holding_position)
            flag_error("holding_position", 32'(want.holding_position),
                       32'(out_data_o.holding_position));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
        holdoff_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Write one window register through a setup and an access cycle
  task automatic write_window(input reg_idx_e idx, input logic [WIN_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx) << CFG_ADDR_LSB;
    pwdata  <= CFG_DATA_BITS'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_SHORT_WINDOW) short_len = value;
    else long_len = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one price after a random gap and hold it until the transfer
  task automatic offer_item(input macs_in_t item, input logic typed, input macs_out_t golden);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    row_typed  <= typed;
    row_golden <= golden;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_signals.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [WIN_BITS-1:0] short_w, input logic [WIN_BITS-1:0] long_w,
                           input int n_items, input logic fresh, input int start_odds,
                           input int idle_pct, input int stall_pct_set, input logic hold_off);
    macs_in_t item;
    write_window(REG_SHORT_WINDOW, short_w);
    write_window(REG_LONG_WINDOW, long_w);
    send_idle_pct = idle_pct;
    stall_pct     = stall_pct_set;
    holdoff_req   = hold_off;
    for (int k = 0; k < n_items; k++) begin
      item = draw_price(start_odds);
      if (k == 0 && fresh) item.series_start = 1'b1;
      offer_item(item, 1'b0, '0);
    end
    drain_results();
  endtask

  initial begin : stimulus
    macs_in_t item;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows at the reset windows
    for (int r = 0; r < DIR_ROWS; r++) begin
      item.close_price  = dir_tab[r].price;
      item.series_start = dir_tab[r].start;
      offer_item(item, dir_tab[r].typed, dir_tab[r].golden);
    end
    drain_results();

    // Random phases; two of them change the windows inside a series
    run_phase(9'd1,   9'd256, 300, 1'b1, 0,  0,  0,  1'b1);
    run_phase(9'd256, 9'd1,   60,  1'b1, 30, 79, 0,  1'b0);
    run_phase(9'd0,   9'd511, 60,  1'b1, 30, 0,  79, 1'b0);
    run_phase(9'd3,   9'd7,   80,  1'b1, 25, 12, 12, 1'b0);
    run_phase(9'd2,   9'd3,   60,  1'b0, 25, 0,  0,  1'b0);
    run_phase(9'd9,   9'd4,   60,  1'b0, 25, 79, 0,  1'b0);
    run_phase(9'd256, 9'd256, 50,  1'b1, 0,  0,  79, 1'b0);
    run_phase(9'd1,   9'd1,   40,  1'b1, 10, 12, 12, 1'b0);

    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (err_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
design/macs_pkg.sv
design/macs_ram.sv
design/macs_cell.sv
design/moving_average_crossover_signal_top.sv
design/macs_checker.sv
bench/tb.sv
